[hdl/mpbt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mpbt_pkg;

  localparam int NUM_SLOTS = 6;
  localparam int WORD_W = 64;
  localparam int LENS_W = 24;
  localparam int LEN_W = 4;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS = 3'd6;

  typedef logic [WORD_W-1:0] pat_word_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       open_tag;
    logic       close_tag;
    logic       final_byte;
    logic       close_after;
  } entry_t;

endpackage
`default_nettype wire

[hdl/mpbt_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpbt_front #(
  parameter int NUM_PATTERNS = 6,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mpbt_pkg::pat_word_t           pat_words [mpbt_pkg::NUM_SLOTS],
  input  wire logic [mpbt_pkg::LENS_W-1:0]   pat_lens,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_last,
  output logic                               dec_valid,
  input  wire logic                          dec_ready,
  output mpbt_pkg::entry_t                   dec
);
  import mpbt_pkg::*;

  localparam int FILL_W = $clog2(MAX_PATTERN_LEN + 1);
  localparam int IDX_W = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam logic [FILL_W-1:0] FULL = FILL_W'(MAX_PATTERN_LEN);

  logic [7:0]        win [MAX_PATTERN_LEN];
  logic [FILL_W-1:0] fill;
  logic              draining;
  logic [LEN_W-1:0]  bold_rem;
  logic              prev_bold;

  logic              emit;
  logic              accept;
  logic [FILL_W-1:0] pos;
  logic [LEN_W-1:0]  best;
  logic [LEN_W-1:0]  rem_eff;
  logic              bold;
  logic              final_now;

  assign emit = (fill == FULL || draining) && fill != '0 && dec_ready;
  assign in_ready = !draining && (fill != FULL || emit);
  assign accept = in_valid && in_ready;
  assign pos = emit ? fill - FILL_W'(1) : fill;

  always_comb begin
    logic [4:0]       len5;
    logic [4:0]       fill5;
    logic             hit;
    logic [LEN_W-1:0] len;
    best = '0;
    fill5 = 5'(fill);
    for (int p = 0; p < NUM_PATTERNS && p < NUM_SLOTS; p++) begin
      len = pat_lens[LEN_W*p +: LEN_W];
      len5 = {1'b0, len};
      hit = len != '0 && len5 <= 5'(MAX_PATTERN_LEN) && len5 <= fill5;
      for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
        if (5'(k) < len5 && win[k] != pat_words[p][8*k +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit && len > best) begin
        best = len;
      end
    end
  end

  assign rem_eff = (best > bold_rem) ? best : bold_rem;
  assign bold = rem_eff != '0;
  assign final_now = draining && fill == FILL_W'(1);

  assign dec_valid = (fill == FULL || draining) && fill != '0;
  always_comb begin
    dec.text_byte = win[0];
    dec.open_tag = bold && !prev_bold;
    dec.close_tag = !bold && prev_bold;
    dec.final_byte = final_now;
    dec.close_after = final_now && bold;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) begin
        win[k] <= win[k+1];
      end
    end
    if (accept) begin
      win[pos[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      draining <= 1'b0;
      bold_rem <= '0;
      prev_bold <= 1'b0;
    end else begin
      fill <= pos + FILL_W'(accept);
      if (accept && in_last) begin
        draining <= 1'b1;
      end
      if (emit) begin
        if (final_now) begin
          draining <= 1'b0;
          bold_rem <= '0;
          prev_bold <= 1'b0;
        end else begin
          bold_rem <= bold ? rem_eff - LEN_W'(1) : '0;
          prev_bold <= bold;
        end
      end
    end
  end

endmodule
`default_nettype wire

[hdl/mpbt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpbt_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire mpbt_pkg::entry_t push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output mpbt_pkg::entry_t      pop_data
);
  import mpbt_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid = count != '0;
  assign pop_data = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

[hdl/mpbt_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpbt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire mpbt_pkg::entry_t q_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            out_byte,
  output logic                  out_last
);
  import mpbt_pkg::*;

  localparam logic [1:0] PH_PRE = 2'd0;
  localparam logic [1:0] PH_CHAR = 2'd1;
  localparam logic [1:0] PH_POST = 2'd2;

  localparam logic [7:0] CH_LT = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_GT = 8'h3E;

  logic [1:0] phase;
  logic [1:0] idx;

  logic [1:0] cur_phase;
  logic [1:0] phase_next;
  logic [1:0] idx_next;
  logic [7:0] byte_now;
  logic       last_now;
  logic       done_entry;
  logic       load;

  function automatic logic [7:0] tag_byte(input logic is_close, input logic [1:0] i);
    logic [7:0] b;
    b = CH_GT;
    if (is_close) begin
      unique case (i)
        2'd0: b = CH_LT;
        2'd1: b = CH_SLASH;
        2'd2: b = CH_B;
        default: b = CH_GT;
      endcase
    end else begin
      unique case (i)
        2'd0: b = CH_LT;
        2'd1: b = CH_B;
        default: b = CH_GT;
      endcase
    end
    return b;
  endfunction

  assign cur_phase = (phase == PH_PRE && !(q_data.open_tag || q_data.close_tag)) ?
                     PH_CHAR : phase;

  always_comb begin
    byte_now = q_data.text_byte;
    last_now = 1'b0;
    done_entry = 1'b0;
    phase_next = phase;
    idx_next = idx;
    unique case (cur_phase)
      PH_PRE: begin
        byte_now = tag_byte(q_data.close_tag, idx);
        if (idx == (q_data.close_tag ? 2'd3 : 2'd2)) begin
          phase_next = PH_CHAR;
          idx_next = 2'd0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      PH_CHAR: begin
        byte_now = q_data.text_byte;
        idx_next = 2'd0;
        if (q_data.close_after) begin
          phase_next = PH_POST;
        end else begin
          last_now = q_data.final_byte;
          done_entry = 1'b1;
          phase_next = PH_PRE;
        end
      end
      PH_POST: begin
        byte_now = tag_byte(1'b1, idx);
        if (idx == 2'd3) begin
          last_now = 1'b1;
          done_entry = 1'b1;
          phase_next = PH_PRE;
          idx_next = 2'd0;
        end else begin
          idx_next = idx + 2'd1;
        end
      end
      default: begin
        phase_next = PH_PRE;
        idx_next = 2'd0;
      end
    endcase
  end

  assign load = q_valid && (!out_valid || out_ready);
  assign q_ready = load && done_entry;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_now;
      out_last <= last_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase <= PH_PRE;
      idx <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase <= phase_next;
        idx <= idx_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/multi_pattern_bold_tagger_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Bold tagger for a byte stream. Text enters on in_valid/in_ready, one character per item,
// with in_last on the final character. Tagged text leaves on out_valid/out_ready, one byte
// per item, with out_last on the final byte. Patterns and their lengths are written on the
// cfg port (index 0 to 5 pattern words, 6 the packed lengths), by the user only while no
// text is in flight, which the block does not enforce; cfg_ready is always high.
// A character waits in an eight-byte lookahead window until the window is full or the text
// ends. The front matches all patterns against the window combinationally and retires one
// character per cycle into a four-entry queue while the queue has room; the back expands
// each entry into its tag and text bytes, one byte per cycle while the receiver takes them.
// In steady state one character is taken per cycle while the queue has room. Each tag slows
// the input once the queue fills, and after in_last the input stays closed until every
// character left in the window has been retired. Reset clears the window, the queue, the
// output register and all patterns. When the receiver stalls, the output byte holds, the
// queue fills, and then in_ready drops.
module multi_pattern_bold_tagger_top #(
  parameter int NUM_PATTERNS = 6,
  parameter int MAX_PATTERN_LEN = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [mpbt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mpbt_pkg::WORD_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             in_last,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [7:0]                            out_byte,
  output logic                                  out_last
);
  import mpbt_pkg::*;

  pat_word_t           pat_words [NUM_SLOTS];
  logic [LENS_W-1:0]   pat_lens;

  logic                dec_valid;
  logic                dec_ready;
  entry_t              dec;
  logic                q_valid;
  logic                q_ready;
  entry_t              q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        pat_words[i] <= '0;
      end
      pat_lens <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index < CFG_LENGTHS) begin
        pat_words[cfg_index] <= cfg_data;
      end else if (cfg_index == CFG_LENGTHS) begin
        pat_lens <= cfg_data[LENS_W-1:0];
      end
    end
  end

  mpbt_front #(
    .NUM_PATTERNS   (NUM_PATTERNS),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pat_words(pat_words),
    .pat_lens (pat_lens),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .dec_valid(dec_valid),
    .dec_ready(dec_ready),
    .dec      (dec)
  );

  mpbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(dec_valid),
    .push_ready(dec_ready),
    .push_data (dec),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_data  (q_data)
  );

  mpbt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_data   (q_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

endmodule
`default_nettype wire

[hdl/mpbt_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module mpbt_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [7:0]                     out_byte,
  input wire logic                           out_last
);

  // A stalled output byte keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("output item changed while stalled");

  // Reset leaves nothing to send and the input open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

  // Register writes are never back-pressured.
  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind multi_pattern_bold_tagger_top mpbt_checker u_mpbt_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_valid(cfg_valid),
  .cfg_ready(cfg_ready),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_byte (out_byte),
  .out_last (out_last)
);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import mpbt_pkg::*;

  localparam int NUM_PATTERNS = 6;
  localparam int MAX_PATTERN_LEN = 8;
  localparam int SETTLE_CYCLES = 3 * MAX_PATTERN_LEN;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 40;

  localparam logic [7:0] CH_LT = "<";
  localparam logic [7:0] CH_GT = ">";
  localparam logic [7:0] CH_B = "b";
  localparam logic [7:0] CH_SLASH = "/";

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WORD_0, REG_WORD_1, REG_WORD_2, REG_WORD_3, REG_WORD_4, REG_WORD_5,
    REG_LENGTHS = CFG_LENGTHS, REG_SPARE
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic out_last;

  multi_pattern_bold_tagger_top #(
    .NUM_PATTERNS(NUM_PATTERNS),
    .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  // Tagger model state and its copy of the pattern registers.
  logic [WORD_W-1:0] pat_word [NUM_SLOTS];
  logic [LENS_W-1:0] pat_lens = '0;
  logic [7:0] window [MAX_PATTERN_LEN];
  int unsigned window_fill = 0;
  int unsigned bold_left = 0;
  bit last_was_bold = 1'b0;
  text_byte_t tagged_bytes_due[$];

  logic [WORD_W-1:0] plan_word [NUM_SLOTS];
  logic [WORD_W-1:0] plan_lens_data;
  logic [7:0] letters[$];
  logic [7:0] text_buf[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 1'b0;
  int errors = 0;
  int texts_sent = 0;
  int chars_sent = 0;
  int bytes_checked = 0;
  int bold_runs = 0;
  int settings_loaded = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < NUM_SLOTS; s++) pat_word[s] = '0;
  end

  function automatic void push_tag_byte(input logic [7:0] b);
    tagged_bytes_due.push_back('{data: b, last: 1'b0});
  endfunction

  function automatic void push_close_tag();
    push_tag_byte(CH_LT);
    push_tag_byte(CH_SLASH);
    push_tag_byte(CH_B);
    push_tag_byte(CH_GT);
  endfunction

  function automatic int unsigned longest_hit();
    int unsigned best;
    int unsigned len;
    bit hit;
    best = 0;
    for (int p = 0; p < NUM_PATTERNS; p++) begin
      len = 32'(pat_lens[LEN_W*p +: LEN_W]);
      if (len == 0 || len > MAX_PATTERN_LEN || len > window_fill) continue;
      hit = 1'b1;
      for (int k = 0; k < len; k++) begin
        if (pat_word[p][8*k +: 8] != window[k]) hit = 1'b0;
      end
      if (hit && len > best) best = len;
    end
    return best;
  endfunction

  function automatic void emit_oldest();
    int unsigned hit_len;
    bit bold;
    hit_len = longest_hit();
    if (hit_len > bold_left) bold_left = hit_len;
    bold = bold_left > 0;
    if (bold) bold_left--;
    if (bold && !last_was_bold) begin
      push_tag_byte(CH_LT);
      push_tag_byte(CH_B);
      push_tag_byte(CH_GT);
      bold_runs++;
    end else if (!bold && last_was_bold) begin
      push_close_tag();
    end
    push_tag_byte(window[0]);
    last_was_bold = bold;
    for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) window[k] = window[k + 1];
    if (window_fill > 0) window_fill--;
  endfunction

  function automatic void predict_char(input logic [7:0] b, input logic last);
    text_byte_t tail;
    if (window_fill < MAX_PATTERN_LEN) begin
      window[window_fill] = b;
      window_fill++;
    end
    if (!last) begin
      if (window_fill >= MAX_PATTERN_LEN) emit_oldest();
    end else begin
      while (window_fill > 0) emit_oldest();
      if (last_was_bold) push_close_tag();
      tail = tagged_bytes_due.pop_back();
      tail.last = 1'b1;
      tagged_bytes_due.push_back(tail);
      window_fill = 0;
      bold_left = 0;
      last_was_bold = 1'b0;
    end
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [WORD_W-1:0] data);
    if (idx == REG_LENGTHS) pat_lens = data[LENS_W-1:0];
    else if (idx != REG_SPARE) pat_word[int'(idx)] = data;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("Mismatch on %s at output byte %0d: expected 0x%0h, got 0x%0h (%0t)",
               what, bytes_checked, want, got, $time);
  endtask

  always @(posedge clk) begin
    text_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (tagged_bytes_due.size() == 0) begin
        report_mismatch("unexpected byte", 0, 32'(out_byte));
      end else begin
        want = tagged_bytes_due.pop_front();
        if (out_byte !== want.data)
          report_mismatch("out_byte", 32'(want.data), 32'(out_byte));
        if (out_last !== want.last)
          report_mismatch("out_last", 32'(want.last), 32'(out_last));
      end
      bytes_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_char(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= last;
    do @(posedge clk); while (!in_ready);
    predict_char(b, last);
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tagged_bytes_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
  endtask

  task automatic load_patterns(input bit with_spare);
    wait_drained();
    for (int k = 0; k < NUM_SLOTS; k++) write_reg(cfg_reg_e'(k), plan_word[k]);
    if (with_spare) write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_LENGTHS, plan_lens_data);
    cfg_valid <= 1'b0;
    settings_loaded++;
  endtask

  task automatic pick_letters(input int n);
    letters.delete();
    repeat (n) letters.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] any_letter();
    return letters[$urandom_range(0, letters.size() - 1)];
  endfunction

  task automatic random_patterns();
    logic [LENS_W-1:0] lens;
    int r;
    pick_letters($urandom_range(2, 4));
    for (int s = 0; s < NUM_SLOTS; s++) begin
      for (int k = 0; k < 8; k++) plan_word[s][8*k +: 8] = any_letter();
      r = $urandom_range(0, 11);
      if (r == 0) lens[LEN_W*s +: LEN_W] = '0;
      else if (r == 1) lens[LEN_W*s +: LEN_W] = LEN_W'($urandom_range(9, 15));
      else if (r < 7) lens[LEN_W*s +: LEN_W] = LEN_W'($urandom_range(1, 4));
      else lens[LEN_W*s +: LEN_W] = LEN_W'($urandom_range(1, 8));
    end
    plan_lens_data = {$urandom, $urandom};
    plan_lens_data[LENS_W-1:0] = lens;
  endtask

  task automatic random_text(input int len);
    int slot;
    int plen;
    int r;
    text_buf.delete();
    while (text_buf.size() < len) begin
      r = $urandom_range(99);
      if (r < 45) begin
        slot = $urandom_range(0, NUM_SLOTS - 1);
        plen = 32'(pat_lens[LEN_W*slot +: LEN_W]);
        if (plen == 0 || plen > MAX_PATTERN_LEN) plen = $urandom_range(1, MAX_PATTERN_LEN);
        for (int k = 0; k < plen; k++) text_buf.push_back(pat_word[slot][8*k +: 8]);
      end else if (r < 90) begin
        text_buf.push_back(any_letter());
      end else begin
        text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (text_buf.size() > len) void'(text_buf.pop_back());
  endtask

  task automatic run_texts(input int n_chars);
    int sent;
    int len;
    sent = 0;
    while (sent < n_chars) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 16) : $urandom_range(17, 40);
      random_text(len);
      send_text();
      sent += len;
    end
  endtask

  task automatic test_reset_state();
    pick_letters(3);
    run_texts(12);
  endtask

  task automatic test_directed_cases();
    plan_word[0] = {48'd0, "ba"};
    plan_word[1] = {40'd0, "cba"};
    plan_word[2] = 64'hFE01_7F80_00FF_00FF;
    plan_word[3] = {48'd0, "zz"};
    plan_word[4] = {56'd0, "x"};
    plan_word[5] = {56'd0, "b"};
    plan_lens_data = 64'h0000_0000_0010_9832;
    load_patterns(1'b1);
    text_buf = '{"x"};
    send_text();
    text_buf = '{"b"};
    send_text();
    text_buf = '{"z", "z"};
    send_text();
    text_buf = '{"x", "a", "b"};
    send_text();
    text_buf = '{"a", "b", "c", "a", "b"};
    send_text();
    text_buf = '{"b", "x", "b"};
    send_text();
    text_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE};
    send_text();
  endtask

  task automatic test_random_flow(input int send_pct, input int recv_pct, input int n_chars);
    for (int pass = 0; pass < 2; pass++) begin
      random_patterns();
      load_patterns(pass == 1);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      run_texts(n_chars / 2);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end
  endtask

  task automatic test_extreme_settings();
    letters = '{8'hFF, 8'h00};
    send_idle_pct = 34;
    recv_stall_pct = 34;
    for (int s = 0; s < NUM_SLOTS; s++) plan_word[s] = '1;
    plan_lens_data = 64'h0000_0000_0088_8888;
    load_patterns(1'b0);
    run_texts(12);
    for (int s = 0; s < NUM_SLOTS; s++) plan_word[s] = '0;
    plan_lens_data = '1;
    load_patterns(1'b1);
    run_texts(12);
    plan_lens_data = 64'h0000_0000_0011_1111;
    load_patterns(1'b0);
    run_texts(12);
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_output_backpressure();
    random_patterns();
    load_patterns(1'b0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        random_text(48);
        send_text();
      end
    join
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_cases();
    test_random_flow(0, 0, 60);
    test_random_flow(80, 0, 60);
    test_random_flow(0, 80, 60);
    test_random_flow(34, 34, 60);
    test_extreme_settings();
    test_output_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d texts (%0d characters) under %0d pattern settings, with idle mixes",
             texts_sent, chars_sent, settings_loaded);
    $display("and a long output hold; checked %0d tagged bytes in %0d bold runs.",
             bytes_checked, bold_runs);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
